// ===== hw/rtl/shbe_pkg.sv =====
// Shared types and constants of the static Huffman byte encoder.
`timescale 1ns / 1ps
`default_nettype none

package shbe_pkg;

  localparam int SYMBOLS_DEF      = 256;
  localparam int MAX_CODE_LEN_DEF = 64;
  localparam int COUNT_BITS_DEF   = 24;
  localparam int WORD_BITS        = 32;

  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_ENCODE = 2'd2,
    REQ_FLUSH  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pixel;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 kind;
    logic                 overflow;
    logic                 last;
  } out_t;

  // Tree builder status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } tree_stat_t;

  // Packer commands
  typedef struct packed {
    logic load;
    logic flush;
  } pk_ctrl_t;

  // Packer status
  typedef struct packed {
    logic busy;
    logic emit;
    logic last;
  } pk_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shbe_hist.sv =====
// Histogram store with per-bin valid bits and registered read.
`timescale 1ns / 1ps
`default_nettype none

module shbe_hist import shbe_pkg::*; #(
  parameter int SYMBOLS    = SYMBOLS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int SW = $clog2(SYMBOLS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clr_i,
  input  wire logic [SW-1:0]         raddr_i,
  output logic      [COUNT_BITS-1:0] rdata_o,
  input  wire logic                  we_i,
  input  wire logic [SW-1:0]         waddr_i,
  input  wire logic [COUNT_BITS-1:0] wdata_i
);

  logic [COUNT_BITS-1:0] mem [SYMBOLS];
  logic [COUNT_BITS-1:0] rd_q;
  logic [SYMBOLS-1:0]    valid_q;
  logic                  rvalid_q;

  // Track written bins; clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[raddr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  // Bin storage
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // A bin never written reads as zero
  assign rdata_o = rvalid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/shbe_tree.sv =====
// Tree builder: min scan, merges, code derivation and bit total over node memories.
`timescale 1ns / 1ps
`default_nettype none

module shbe_tree import shbe_pkg::*; #(
  parameter int SYMBOLS      = SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  localparam int SW = $clog2(SYMBOLS),
  localparam int LW = $clog2(MAX_CODE_LEN + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output tree_stat_t                   stat_o,
  output logic      [SW-1:0]           hist_raddr_o,
  input  wire logic [COUNT_BITS-1:0]   hist_rdata_i,
  input  wire logic [SW-1:0]           lk_addr_i,
  output logic      [MAX_CODE_LEN-1:0] code_o,
  output logic      [LW-1:0]           len_o,
  output logic      [WORD_BITS-1:0]    total_o
);

  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int NW    = $clog2(NODES);
  localparam int CW    = LW + MAX_CODE_LEN;
  localparam int PW    = COUNT_BITS + LW;
  localparam int AW    = ((PW > WORD_BITS) ? PW : WORD_BITS) + 1;

  typedef enum logic [3:0] {
    T_IDLE, T_LD_RD, T_LD_WR, T_SCAN, T_MW1, T_MW2, T_MW3,
    T_ROOT, T_CR1, T_CR2, T_CR3, T_SM1, T_SM2, T_SM3
  } tst_e;

  // Node memories: {parented, weight}, {is_one, parent}, {length, code}
  logic [COUNT_BITS:0] wmem [NODES];
  logic [NW:0]         lmem [NODES];
  logic [CW-1:0]       cmem [NODES];
  logic [COUNT_BITS:0] w_rd_q;
  logic [NW:0]         l_rd_q;
  logic [CW-1:0]       c_rd_q;

  logic                w_we, l_we, c_we;
  logic [NW-1:0]       w_waddr, l_waddr, c_waddr, c_raddr;
  logic [COUNT_BITS:0] w_wdata;
  logic [NW:0]         l_wdata;
  logic [CW-1:0]       c_wdata;

  tst_e                  st_q;
  logic [SW-1:0]         s_q;
  logic [NW-1:0]         i_q, j_q, pj_q, bi_q, si_q;
  logic                  pv_q, bv_q, sv_q, one_q;
  logic [COUNT_BITS-1:0] bw_q, sw_q;
  logic [PW-1:0]         prod_q;
  logic [WORD_BITS-1:0]  acc_q;
  logic                  done_q, ovf_q;

  logic [COUNT_BITS-1:0] scan_w;
  logic [COUNT_BITS:0]   sum_w;
  logic [COUNT_BITS-1:0] sum_sat;
  logic [LW-1:0]         len_p;
  logic [MAX_CODE_LEN-1:0] code_p;
  logic                  too_deep;
  logic [AW-1:0]         acc_sum;

  assign scan_w   = w_rd_q[COUNT_BITS-1:0];
  assign sum_w    = {1'b0, bw_q} + {1'b0, sw_q};
  assign sum_sat  = sum_w[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_w[COUNT_BITS-1:0];
  assign len_p    = c_rd_q[CW-1:MAX_CODE_LEN];
  assign code_p   = c_rd_q[MAX_CODE_LEN-1:0];
  assign too_deep = (32'(len_p) >= 32'(MAX_CODE_LEN));
  assign acc_sum  = AW'(acc_q) + AW'(prod_q);

  // Memory port selection by step
  always_comb begin
    w_we    = 1'b0;
    w_waddr = i_q;
    w_wdata = {1'b0, sum_sat};
    l_we    = 1'b0;
    l_waddr = bi_q;
    l_wdata = {1'b1, i_q};
    c_we    = 1'b0;
    c_waddr = i_q;
    c_wdata = '0;
    c_raddr = NW'(lk_addr_i);
    unique case (st_q)
      T_LD_WR: begin
        w_we    = 1'b1;
        w_waddr = NW'(s_q);
        w_wdata = {1'b0, hist_rdata_i};
      end
      T_MW1: begin
        w_we = 1'b1;
        l_we = 1'b1;
      end
      T_MW2: begin
        w_we    = 1'b1;
        w_waddr = bi_q;
        w_wdata = {1'b1, bw_q};
        l_we    = 1'b1;
        l_waddr = si_q;
        l_wdata = {1'b0, i_q};
      end
      T_MW3: begin
        w_we    = 1'b1;
        w_waddr = si_q;
        w_wdata = {1'b1, sw_q};
      end
      T_ROOT: begin
        c_we    = 1'b1;
        c_waddr = NW'(NODES - 1);
      end
      T_CR2: begin
        c_raddr = l_rd_q[NW-1:0];
      end
      T_CR3: begin
        c_we = 1'b1;
        if (too_deep) begin
          c_wdata = {LW'(MAX_CODE_LEN), code_p};
        end else begin
          c_wdata = {len_p + LW'(1), code_p[MAX_CODE_LEN-2:0], one_q};
        end
      end
      T_SM1: begin
        c_raddr = NW'(s_q);
      end
      default: begin
      end
    endcase
  end

  // Node memories, registered reads
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (l_we) begin
      lmem[l_waddr] <= l_wdata;
    end
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    w_rd_q <= wmem[j_q];
    l_rd_q <= lmem[i_q];
    c_rd_q <= cmem[c_raddr];
  end

  // Build sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= T_IDLE;
      s_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      pj_q   <= '0;
      bi_q   <= '0;
      si_q   <= '0;
      pv_q   <= 1'b0;
      bv_q   <= 1'b0;
      sv_q   <= 1'b0;
      one_q  <= 1'b0;
      bw_q   <= '0;
      sw_q   <= '0;
      prod_q <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      unique case (st_q)
        T_IDLE: begin
          if (start_i) begin
            s_q  <= '0;
            st_q <= T_LD_RD;
          end
        end
        // Copy histogram bins into the leaves
        T_LD_RD: st_q <= T_LD_WR;
        T_LD_WR: begin
          if (s_q == SW'(SYMBOLS - 1)) begin
            i_q  <= NW'(SYMBOLS);
            j_q  <= '0;
            pv_q <= 1'b0;
            bv_q <= 1'b0;
            sv_q <= 1'b0;
            st_q <= T_SCAN;
          end else begin
            s_q  <= s_q + SW'(1);
            st_q <= T_LD_RD;
          end
        end
        // Track the two lightest unparented nodes, lowest index on ties
        T_SCAN: begin
          if (pv_q && !w_rd_q[COUNT_BITS]) begin
            if (!bv_q || scan_w < bw_q) begin
              sv_q <= bv_q;
              si_q <= bi_q;
              sw_q <= bw_q;
              bv_q <= 1'b1;
              bi_q <= pj_q;
              bw_q <= scan_w;
            end else if (!sv_q || scan_w < sw_q) begin
              sv_q <= 1'b1;
              si_q <= pj_q;
              sw_q <= scan_w;
            end
          end
          if (j_q != i_q) begin
            pv_q <= 1'b1;
            pj_q <= j_q;
            j_q  <= j_q + NW'(1);
          end else begin
            pv_q <= 1'b0;
            if (!pv_q) begin
              st_q <= T_MW1;
            end
          end
        end
        T_MW1: begin
          ovf_q <= sum_w[COUNT_BITS];
          st_q  <= T_MW2;
        end
        T_MW2: st_q <= T_MW3;
        T_MW3: begin
          if (i_q == NW'(NODES - 1)) begin
            st_q <= T_ROOT;
          end else begin
            i_q  <= i_q + NW'(1);
            j_q  <= '0;
            pv_q <= 1'b0;
            bv_q <= 1'b0;
            sv_q <= 1'b0;
            st_q <= T_SCAN;
          end
        end
        // Derive codes from the root downward
        T_ROOT: begin
          i_q  <= NW'(NODES - 2);
          st_q <= T_CR1;
        end
        T_CR1: st_q <= T_CR2;
        T_CR2: begin
          one_q <= l_rd_q[NW];
          st_q  <= T_CR3;
        end
        T_CR3: begin
          ovf_q <= too_deep;
          if (i_q == '0) begin
            s_q   <= '0;
            acc_q <= '0;
            st_q  <= T_SM1;
          end else begin
            i_q  <= i_q - NW'(1);
            st_q <= T_CR1;
          end
        end
        // Accumulate count times length per symbol
        T_SM1: st_q <= T_SM2;
        T_SM2: begin
          prod_q <= PW'(hist_rdata_i) * PW'(len_p);
          st_q   <= T_SM3;
        end
        T_SM3: begin
          if (|acc_sum[AW-1:WORD_BITS]) begin
            acc_q <= {WORD_BITS{1'b1}};
            ovf_q <= 1'b1;
          end else begin
            acc_q <= acc_sum[WORD_BITS-1:0];
          end
          if (s_q == SW'(SYMBOLS - 1)) begin
            done_q <= 1'b1;
            st_q   <= T_IDLE;
          end else begin
            s_q  <= s_q + SW'(1);
            st_q <= T_SM1;
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  assign hist_raddr_o = s_q;
  assign code_o       = code_p;
  assign len_o        = len_p;
  assign total_o      = acc_q;
  assign stat_o       = '{busy: (st_q != T_IDLE), done: done_q, ovf: ovf_q};

endmodule

`default_nettype wire

// ===== hw/rtl/shbe_packer.sv =====
// Bit packer: shifts code bits MSB-first into 32-bit words and pads on flush.
`timescale 1ns / 1ps
`default_nettype none

module shbe_packer import shbe_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int LW = $clog2(MAX_CODE_LEN + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire pk_ctrl_t                ctrl_i,
  input  wire logic [MAX_CODE_LEN-1:0] code_i,
  input  wire logic [LW-1:0]           len_i,
  input  wire logic                    grant_i,
  output pk_stat_t                     stat_o,
  output logic      [WORD_BITS-1:0]    word_o
);

  localparam int IW = $clog2(MAX_CODE_LEN);

  typedef enum logic [1:0] {P_IDLE, P_SHIFT, P_FLUSH} pst_e;

  pst_e                  st_q;
  logic [WORD_BITS-1:0]  buf_q;
  logic [4:0]            fill_q;
  logic [MAX_CODE_LEN-1:0] cq_q;
  logic [LW-1:0]         rl_q;

  logic [LW-1:0]         rl_m1;
  logic                  bit_w;
  logic [WORD_BITS-1:0]  shifted;
  logic [WORD_BITS-1:0]  flush_w;
  logic                  full_w;
  logic                  emit_w;

  assign rl_m1   = rl_q - LW'(1);
  assign bit_w   = cq_q[rl_m1[IW-1:0]];
  assign shifted = {buf_q[WORD_BITS-2:0], bit_w};
  assign flush_w = buf_q << (6'd32 - {1'b0, fill_q});
  assign full_w  = (fill_q == 5'd31);
  assign emit_w  = ((st_q == P_SHIFT) && full_w) || ((st_q == P_FLUSH) && (fill_q != '0));

  assign word_o = (st_q == P_FLUSH) ? flush_w : shifted;
  assign stat_o = '{busy: (st_q != P_IDLE),
                    emit: emit_w,
                    last: (st_q == P_FLUSH) || (32'(rl_m1) < 32'(WORD_BITS))};

  // Shift one bit per cycle; a full word waits for its grant
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= P_IDLE;
      buf_q  <= '0;
      fill_q <= '0;
      cq_q   <= '0;
      rl_q   <= '0;
    end else begin
      unique case (st_q)
        P_IDLE: begin
          if (ctrl_i.load) begin
            cq_q <= code_i;
            rl_q <= len_i;
            if (len_i != '0) begin
              st_q <= P_SHIFT;
            end
          end else if (ctrl_i.flush) begin
            st_q <= P_FLUSH;
          end
        end
        P_SHIFT: begin
          if (!full_w || grant_i) begin
            if (full_w) begin
              buf_q  <= '0;
              fill_q <= '0;
            end else begin
              buf_q  <= shifted;
              fill_q <= fill_q + 5'd1;
            end
            rl_q <= rl_m1;
            if (rl_m1 == '0) begin
              st_q <= P_IDLE;
            end
          end
        end
        P_FLUSH: begin
          if ((fill_q == '0) || grant_i) begin
            buf_q  <= '0;
            fill_q <= '0;
            st_q   <= P_IDLE;
          end
        end
        default: st_q <= P_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/static_huffman_byte_encoder.sv =====
// Top level of the static Huffman byte encoder: request sequencer and output register.
//
// Input words carry a request type and a pixel on in_valid_i/in_ready_o; result
// words leave on out_valid_o/out_ready_i through a one-word output register.
// in_ready_o is high only while the sequencer is idle; one request at a time.
// Count: histogram read, then saturating write; no result.
// Encode: code lookup, then the packer shifts one code bit per cycle, stalling
//   while a full word waits for the output register.
// Flush: emits the padded partial word if any, waiting on the output register.
// Build: copies the histogram into the leaves, merges nodes, derives codes and
//   sums the bits; its minimum scan reads one node of the weight memory per cycle.
//   It ends with one total-bits word.
// Reset clears histogram valid bits, bit buffer, fill and overflow flag at once;
// no clearing pass is needed. Code memories are undefined until the first build.
// When the receiver stalls, a full output register holds and the packer stalls
// on its next full word; input stays blocked until the request completes.
`timescale 1ns / 1ps
`default_nettype none

module static_huffman_byte_encoder import shbe_pkg::*; #(
  parameter int SYMBOLS      = SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int SW = $clog2(SYMBOLS);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_ENC, S_ENC_RUN, S_BUILD, S_BLD_OUT, S_FLUSH
  } st_e;

  st_e           st_q;
  logic [SW-1:0] px_q;
  logic          sticky_q;
  logic          out_valid_q;
  out_t          out_q;

  logic                  in_acc;
  logic                  px_ok;
  req_e                  req;
  logic                  out_free;
  logic                  grant;

  logic [SW-1:0]         h_raddr;
  logic [COUNT_BITS-1:0] h_rdata;
  logic                  h_we;
  logic [COUNT_BITS-1:0] h_wdata;
  logic                  h_sat;
  logic                  h_clr;

  tree_stat_t              tree_stat;
  logic [SW-1:0]           tree_hraddr;
  logic [MAX_CODE_LEN-1:0] tree_code;
  logic [LW-1:0]           tree_len;
  logic [WORD_BITS-1:0]    tree_total;

  pk_ctrl_t             pk_ctrl;
  pk_stat_t             pk_stat;
  logic [WORD_BITS-1:0] pk_word;

  assign in_ready_o = (st_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign px_ok      = ({1'b0, in_data_i.pixel} < 9'(SYMBOLS));
  assign req        = req_e'(in_data_i.req_type);
  assign out_free   = !out_valid_q || out_ready_i;
  assign grant      = pk_stat.emit && out_free;

  // Histogram port: tree owns the read side during a build
  assign h_raddr = (st_q == S_BUILD) ? tree_hraddr : in_data_i.pixel[SW-1:0];
  assign h_sat   = &h_rdata;
  assign h_we    = (st_q == S_CNT) && !h_sat;
  assign h_wdata = h_rdata + COUNT_BITS'(1);
  assign h_clr   = (st_q == S_FLUSH) && !pk_stat.busy;

  assign pk_ctrl = '{load: (st_q == S_ENC), flush: in_acc && (req == REQ_FLUSH)};

  shbe_hist #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (h_clr),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata),
    .we_i    (h_we),
    .waddr_i (px_q),
    .wdata_i (h_wdata)
  );

  shbe_tree #(
    .SYMBOLS      (SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_acc && (req == REQ_BUILD)),
    .stat_o       (tree_stat),
    .hist_raddr_o (tree_hraddr),
    .hist_rdata_i (h_rdata),
    .lk_addr_i    (in_data_i.pixel[SW-1:0]),
    .code_o       (tree_code),
    .len_o        (tree_len),
    .total_o      (tree_total)
  );

  shbe_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pk_ctrl),
    .code_i  (tree_code),
    .len_i   (tree_len),
    .grant_i (grant),
    .stat_o  (pk_stat),
    .word_o  (pk_word)
  );

  // Sequence requests, hold the overflow flag and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      px_q        <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (tree_stat.ovf) begin
        sticky_q <= 1'b1;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            px_q <= in_data_i.pixel[SW-1:0];
            unique case (req)
              REQ_COUNT:  if (px_ok) st_q <= S_CNT;
              REQ_BUILD:  st_q <= S_BUILD;
              REQ_ENCODE: if (px_ok) st_q <= S_ENC;
              REQ_FLUSH:  st_q <= S_FLUSH;
              default:    st_q <= S_IDLE;
            endcase
          end
        end
        S_CNT: begin
          if (h_sat) begin
            sticky_q <= 1'b1;
          end
          st_q <= S_IDLE;
        end
        S_ENC: st_q <= S_ENC_RUN;
        S_ENC_RUN: begin
          if (!pk_stat.busy) begin
            st_q <= S_IDLE;
          end
        end
        S_BUILD: begin
          if (tree_stat.done) begin
            st_q <= S_BLD_OUT;
          end
        end
        S_BLD_OUT: begin
          if (out_free) begin
            st_q <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!pk_stat.busy) begin
            sticky_q <= 1'b0;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase

      // Load the output register from the packer or the build total
      if (grant) begin
        out_valid_q <= 1'b1;
        out_q       <= '{word: pk_word, kind: KIND_WORD, overflow: sticky_q,
                         last: pk_stat.last};
      end else if ((st_q == S_BLD_OUT) && out_free) begin
        out_valid_q <= 1'b1;
        out_q       <= '{word: tree_total, kind: KIND_TOTAL, overflow: sticky_q,
                         last: 1'b1};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!pk_stat.busy && !tree_stat.busy))
    else $error("input ready while a unit is busy");

  a_done_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_stat.done |-> (st_q == S_BUILD))
    else $error("tree done outside a build");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pk_ctrl.load |-> !pk_stat.busy)
    else $error("packer loaded while busy");
`endif

endmodule

`default_nettype wire
